FILE: hdl/aabb_collision_table_unit_assert.svh
// assertion macros for the collision table unit
// expects clk and rst_n in the scope of the module that uses them
`ifndef AABB_COLLISION_TABLE_UNIT_ASSERT_SVH
`define AABB_COLLISION_TABLE_UNIT_ASSERT_SVH

// consequence checked in the same cycle
`define AACT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence checked in the next cycle
`define AACT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/aact_pkg.sv
// shared types, codes and helpers for the collision table unit
// no dependencies
package aact_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int SLOT_AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int FIELD_SLOT_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [2:0] ACT_ADD = 3'd0;
    localparam logic [2:0] ACT_DELETE = 3'd1;
    localparam logic [2:0] ACT_MOVE = 3'd2;
    localparam logic [2:0] ACT_SCAN = 3'd3;
    localparam logic [2:0] ACT_CLEAR = 3'd4;

    localparam logic [2:0] RK_ADDED = 3'd0;
    localparam logic [2:0] RK_FULL = 3'd1;
    localparam logic [2:0] RK_ACK = 3'd2;
    localparam logic [2:0] RK_EVENT = 3'd3;
    localparam logic [2:0] RK_NONE = 3'd4;

    typedef struct packed {
        logic [14:0]        h;
        logic [14:0]        w;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } rect_t;

    typedef struct packed {
        logic [3:0] kind;
        logic       handler;
    } attr_t;

    typedef logic [3:0][CFG_DATA_W-1:0] matrix_t;

    typedef struct packed {
        logic fwd;
        logic rev;
    } pair_hit_t;

    function automatic logic kind_notify(matrix_t m, logic [3:0] owner, logic [3:0] other);
        return m[owner[3:2]][{owner[1:0], other}];
    endfunction

endpackage

FILE: hdl/aact_dp_ram.sv
// generic memory: one write port, two read ports with registered data
// no dependencies
module aact_dp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]                       rd_data_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]                       rd_data_b
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[wr_addr] <= wr_data;
        end
        rd_a_reg <= ram_reg[rd_addr_a];
        rd_b_reg <= ram_reg[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

FILE: hdl/aact_pair_eval.sv
// overlap test and notify lookup for one slot pair
// depends on aact_pkg
module aact_pair_eval
    import aact_pkg::*;
(
    input  rect_t     rect_a,
    input  rect_t     rect_b,
    input  attr_t     attr_a,
    input  attr_t     attr_b,
    input  matrix_t   matrix,
    output pair_hit_t hit
);

    logic signed [16:0] ax_lo;
    logic signed [16:0] ax_hi;
    logic signed [16:0] bx_lo;
    logic signed [16:0] bx_hi;
    logic signed [16:0] ay_lo;
    logic signed [16:0] ay_hi;
    logic signed [16:0] by_lo;
    logic signed [16:0] by_hi;
    logic               overlap;

    // edges in 17 bits so right and bottom never wrap
    assign ax_lo = {rect_a.x[15], rect_a.x};
    assign bx_lo = {rect_b.x[15], rect_b.x};
    assign ay_lo = {rect_a.y[15], rect_a.y};
    assign by_lo = {rect_b.y[15], rect_b.y};
    assign ax_hi = ax_lo + $signed({2'b00, rect_a.w});
    assign bx_hi = bx_lo + $signed({2'b00, rect_b.w});
    assign ay_hi = ay_lo + $signed({2'b00, rect_a.h});
    assign by_hi = by_lo + $signed({2'b00, rect_b.h});

    assign overlap = (ax_lo < bx_hi) && (ax_hi > bx_lo) && (ay_lo < by_hi) && (ay_hi > by_lo);

    assign hit.fwd = overlap && attr_a.handler && kind_notify(matrix, attr_a.kind, attr_b.kind);
    assign hit.rev = overlap && attr_b.handler && kind_notify(matrix, attr_b.kind, attr_a.kind);

endmodule

FILE: hdl/aabb_collision_table_unit.sv
// top level of the rectangle collision table
// depends on aact_pkg, aact_dp_ram, aact_pair_eval and the assertion macro header
//
// usage:
//   command channel (cmd_valid/cmd_stall) carries action, slot, rectangle, kind
//   and handler flag; result channel (rsp_valid/rsp_stall) returns result_kind,
//   owner_slot, other_slot and last, last marking the final result of a command
//   cfg_we/cfg_index/cfg_data write the four 64-bit kind matrix rows while idle
//   add, mark delete, move, clear and unknown actions give a single result,
//   registered in the output register in the cycle after the command is taken
//   scan starts in S_RD and walks each pair of slots: a pair with an unused
//   slot is passed over in S_RD, a pair of used slots goes through S_RD, S_EV
//   and S_PUSH, which stays for each event, and the scan ends in S_FIN; the
//   pair sequencer reads both ports of the slot memory
//   one command is in work at a time; commands are stalled during a scan and
//   while an unread result blocks the output register
//   a stalled result holds in the output register; the scan waits on it
//   reset empties the table and zeroes the matrix; slot memory is not cleared
`include "aabb_collision_table_unit_assert.svh"

module aabb_collision_table_unit
    import aact_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    output logic                    cmd_stall,
    input  logic [2:0]              action,
    input  logic [2:0]              slot,
    input  logic signed [15:0]      left_x,
    input  logic signed [15:0]      top_y,
    input  logic [14:0]             box_width,
    input  logic [14:0]             box_height,
    input  logic [3:0]              collider_kind,
    input  logic                    has_handler,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output logic [2:0]              result_kind,
    output logic [2:0]              owner_slot,
    output logic [2:0]              other_slot,
    output logic                    last,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EV,
        S_PUSH,
        S_FIN
    } state_t;

    localparam logic [SLOT_AW-1:0] LAST_I = SLOT_AW'(NUM_SLOTS - 2);
    localparam logic [SLOT_AW-1:0] LAST_K = SLOT_AW'(NUM_SLOTS - 1);

    state_t                  state_reg, state_next;
    logic [NUM_SLOTS-1:0]    used_reg, used_next;
    logic [NUM_SLOTS-1:0]    pend_reg, pend_next;
    matrix_t                 matrix_reg, matrix_next;
    logic [SLOT_AW-1:0]      i_reg, i_next;
    logic [SLOT_AW-1:0]      k_reg, k_next;
    logic                    fwd_reg, fwd_next;
    logic                    rev_reg, rev_next;
    logic                    hold_valid_reg, hold_valid_next;
    logic [SLOT_AW-1:0]      hold_owner_reg, hold_owner_next;
    logic [SLOT_AW-1:0]      hold_other_reg, hold_other_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    logic [2:0]              kind_reg, kind_next;
    logic [2:0]              owner_reg, owner_next;
    logic [2:0]              other_reg, other_next;
    logic                    last_reg, last_next;

    logic                    out_free;
    logic                    cmd_take;
    logic                    free_found;
    logic [SLOT_AW-1:0]      free_idx;
    logic                    slot_ok;
    logic [SLOT_AW-1:0]      slot_idx;
    logic                    rect_we;
    logic                    attr_we;
    logic [SLOT_AW-1:0]      wr_addr;
    rect_t                   wr_rect;
    attr_t                   wr_attr;
    rect_t                   rect_a;
    rect_t                   rect_b;
    attr_t                   attr_a;
    attr_t                   attr_b;
    pair_hit_t               hit;
    logic [SLOT_AW-1:0]      new_owner;
    logic [SLOT_AW-1:0]      new_other;

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall = (state_reg != S_IDLE) || !out_free;
    assign cmd_take = cmd_valid && !cmd_stall;

    assign slot_ok = {1'b0, slot} < 4'(NUM_SLOTS);
    assign slot_idx = slot[SLOT_AW-1:0];
    assign wr_addr = (action == ACT_ADD) ? free_idx : slot_idx;
    assign wr_rect = '{h: box_height, w: box_width, y: top_y, x: left_x};
    assign wr_attr = '{kind: collider_kind, handler: has_handler};

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx = '0;
        for (int n = NUM_SLOTS - 1; n >= 0; n--)
        begin
            if (!used_reg[n])
            begin
                free_found = 1'b1;
                free_idx = SLOT_AW'(n);
            end
        end
    end

    aact_dp_ram #(
        .WIDTH ($bits(rect_t)),
        .DEPTH (NUM_SLOTS)
    ) u_rect_ram (
        .clk       (clk),
        .we        (rect_we),
        .wr_addr   (wr_addr),
        .wr_data   (wr_rect),
        .rd_addr_a (i_reg),
        .rd_data_a (rect_a),
        .rd_addr_b (k_reg),
        .rd_data_b (rect_b)
    );

    aact_dp_ram #(
        .WIDTH ($bits(attr_t)),
        .DEPTH (NUM_SLOTS)
    ) u_attr_ram (
        .clk       (clk),
        .we        (attr_we),
        .wr_addr   (wr_addr),
        .wr_data   (wr_attr),
        .rd_addr_a (i_reg),
        .rd_data_a (attr_a),
        .rd_addr_b (k_reg),
        .rd_data_b (attr_b)
    );

    aact_pair_eval u_pair_eval (
        .rect_a (rect_a),
        .rect_b (rect_b),
        .attr_a (attr_a),
        .attr_b (attr_b),
        .matrix (matrix_reg),
        .hit    (hit)
    );

    assign new_owner = fwd_reg ? i_reg : k_reg;
    assign new_other = fwd_reg ? k_reg : i_reg;

    always_comb
    begin
        state_next = state_reg;
        used_next = used_reg;
        pend_next = pend_reg;
        matrix_next = matrix_reg;
        i_next = i_reg;
        k_next = k_reg;
        fwd_next = fwd_reg;
        rev_next = rev_reg;
        hold_valid_next = hold_valid_reg;
        hold_owner_next = hold_owner_reg;
        hold_other_next = hold_other_reg;
        rsp_valid_next = rsp_valid_reg;
        kind_next = kind_reg;
        owner_next = owner_reg;
        other_next = other_reg;
        last_next = last_reg;
        rect_we = 1'b0;
        attr_we = 1'b0;

        if (out_free)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            matrix_next[cfg_index] = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    rsp_valid_next = 1'b1;
                    kind_next = RK_ACK;
                    owner_next = '0;
                    other_next = '0;
                    last_next = 1'b1;
                    case (action)
                        ACT_ADD:
                        begin
                            if (free_found)
                            begin
                                used_next[free_idx] = 1'b1;
                                pend_next[free_idx] = 1'b0;
                                rect_we = 1'b1;
                                attr_we = 1'b1;
                                kind_next = RK_ADDED;
                                owner_next = FIELD_SLOT_W'(free_idx);
                            end
                            else
                            begin
                                kind_next = RK_FULL;
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (slot_ok && used_reg[slot_idx])
                            begin
                                pend_next[slot_idx] = 1'b1;
                            end
                        end
                        ACT_MOVE:
                        begin
                            rect_we = slot_ok;
                        end
                        ACT_CLEAR:
                        begin
                            used_next = '0;
                            pend_next = '0;
                        end
                        ACT_SCAN:
                        begin
                            // free flagged slots, then walk the pairs
                            rsp_valid_next = 1'b0;
                            used_next = used_reg & ~pend_reg;
                            pend_next = '0;
                            i_next = '0;
                            k_next = SLOT_AW'(1);
                            hold_valid_next = 1'b0;
                            state_next = S_RD;
                        end
                        default:
                        begin
                            kind_next = RK_ACK;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                if (used_reg[i_reg] && used_reg[k_reg])
                begin
                    state_next = S_EV;
                end
                else if (k_reg != LAST_K)
                begin
                    k_next = k_reg + SLOT_AW'(1);
                end
                else if (i_reg != LAST_I)
                begin
                    i_next = i_reg + SLOT_AW'(1);
                    k_next = i_reg + SLOT_AW'(2);
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_EV:
            begin
                fwd_next = hit.fwd;
                rev_next = hit.rev;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (fwd_reg || rev_reg)
                begin
                    // one event is held back so the final one can carry last
                    if (!hold_valid_reg || out_free)
                    begin
                        if (hold_valid_reg)
                        begin
                            rsp_valid_next = 1'b1;
                            kind_next = RK_EVENT;
                            owner_next = FIELD_SLOT_W'(hold_owner_reg);
                            other_next = FIELD_SLOT_W'(hold_other_reg);
                            last_next = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_owner_next = new_owner;
                        hold_other_next = new_other;
                        if (fwd_reg)
                        begin
                            fwd_next = 1'b0;
                        end
                        else
                        begin
                            rev_next = 1'b0;
                        end
                    end
                end
                else if (k_reg != LAST_K)
                begin
                    k_next = k_reg + SLOT_AW'(1);
                    state_next = S_RD;
                end
                else if (i_reg != LAST_I)
                begin
                    i_next = i_reg + SLOT_AW'(1);
                    k_next = i_reg + SLOT_AW'(2);
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    last_next = 1'b1;
                    if (hold_valid_reg)
                    begin
                        kind_next = RK_EVENT;
                        owner_next = FIELD_SLOT_W'(hold_owner_reg);
                        other_next = FIELD_SLOT_W'(hold_other_reg);
                    end
                    else
                    begin
                        kind_next = RK_NONE;
                        owner_next = '0;
                        other_next = '0;
                    end
                    hold_valid_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg <= '0;
            pend_reg <= '0;
            matrix_reg <= '0;
            i_reg <= '0;
            k_reg <= SLOT_AW'(1);
            fwd_reg <= 1'b0;
            rev_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
            hold_owner_reg <= '0;
            hold_other_reg <= '0;
            rsp_valid_reg <= 1'b0;
            kind_reg <= '0;
            owner_reg <= '0;
            other_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg <= used_next;
            pend_reg <= pend_next;
            matrix_reg <= matrix_next;
            i_reg <= i_next;
            k_reg <= k_next;
            fwd_reg <= fwd_next;
            rev_reg <= rev_next;
            hold_valid_reg <= hold_valid_next;
            hold_owner_reg <= hold_owner_next;
            hold_other_reg <= hold_other_next;
            rsp_valid_reg <= rsp_valid_next;
            kind_reg <= kind_next;
            owner_reg <= owner_next;
            other_reg <= other_next;
            last_reg <= last_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign result_kind = kind_reg;
    assign owner_slot = owner_reg;
    assign other_slot = other_reg;
    assign last = last_reg;

    `AACT_ASSERT_NOW(a_pend_only_used, 1'b1, (pend_reg & ~used_reg) == '0,
        "delete flag set on a free slot")
    `AACT_ASSERT_NOW(a_pair_order, state_reg != S_IDLE, k_reg > i_reg,
        "pair walk lost i below k")
    `AACT_ASSERT_NOW(a_hold_distinct, hold_valid_reg, hold_owner_reg != hold_other_reg,
        "held event pairs a slot with itself")
    `AACT_ASSERT_NOW(a_not_last_is_event, rsp_valid_reg && !last_reg, kind_reg == RK_EVENT,
        "non-final result that is not an event")
    `AACT_ASSERT_NEXT(a_scan_quiet_start, cmd_take && (action == ACT_SCAN),
        !hold_valid_reg && (pend_reg == '0), "scan started with stale state")

endmodule
